// ----- design/xmodem_packet_receiver_unit_assert.svh -----
// Assertion macros for the XMODEM receiver design files.
// No dependencies; included by the top level.
`ifndef XMODEM_PACKET_RECEIVER_UNIT_ASSERT_SVH
`define XMODEM_PACKET_RECEIVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XMR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/xmr_pkg.sv -----
// Shared types, codes and constants for the XMODEM receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package xmr_pkg;

  localparam int unsigned OFFSET_WIDTH_DEFAULT      = 24;
  localparam int unsigned MAX_STARTUP_TRIES_DEFAULT = 32;

  // Command codes of an input item.
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_SUB = 8'h1A;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CRC = 8'h43;

  // Status codes of a result item.
  localparam logic [2:0] STATUS_BUSY      = 3'd0;
  localparam logic [2:0] STATUS_COMPLETE  = 3'd1;
  localparam logic [2:0] STATUS_CANCELLED = 3'd2;
  localparam logic [2:0] STATUS_ESCAPE    = 3'd3;
  localparam logic [2:0] STATUS_SEQ_ERR   = 3'd4;
  localparam logic [2:0] STATUS_BAD_HDR   = 3'd5;
  localparam logic [2:0] STATUS_TIMEOUT   = 3'd6;
  localparam logic [2:0] STATUS_NO_RESP   = 3'd7;

  localparam int unsigned IDX_WIDTH     = 11;
  localparam logic [10:0] PKT_LEN_SHORT = 11'd128;
  localparam logic [10:0] PKT_LEN_LONG  = 11'd1024;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register addresses (byte addresses).
  localparam int unsigned CFG_ADDR_WIDTH = 3;
  localparam logic        CFG_IDX_USE_CRC = 1'b0;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        wr_valid;
    logic [23:0] wr_offset;
    logic [7:0]  wr_byte;
    logic [2:0]  status;
    logic [23:0] total_bytes;
  } out_item_t;

endpackage

// ----- design/xmr_crc16_step.sv -----
// One-byte update of CRC-16/XMODEM (polynomial 0x1021, MSB first).
// Depends on xmr_pkg for the polynomial.
`timescale 1ns / 1ps

module xmr_crc16_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import xmr_pkg::*;

  logic [15:0] acc;

  always_comb begin
    acc = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_o = acc;
  end

endmodule

// ----- design/xmodem_packet_receiver_unit.sv -----
// XMODEM receiver: an item is accepted into the input register, and its result
// item is then written into the result register once that register is free.
// Throughput is one item per cycle while the result side does not stall; the
// state update and byte CRC are computed combinationally from the input register.
// One item is buffered while the result side stalls.
// Asynchronous active-low reset returns the transfer state to idle with
// expected sequence 1 and clears use_crc; no clearing pass is needed.
`timescale 1ns / 1ps

module xmodem_packet_receiver_unit #(
  parameter int unsigned OFFSET_WIDTH      = xmr_pkg::OFFSET_WIDTH_DEFAULT,
  parameter int unsigned MAX_STARTUP_TRIES = xmr_pkg::MAX_STARTUP_TRIES_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  xmr_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output xmr_pkg::out_item_t                 out_item_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xmr_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import xmr_pkg::*;

  `include "xmodem_packet_receiver_unit_assert.svh"

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_HEADER   = 4'd2,
    PH_SEQ      = 4'd3,
    PH_SEQINV   = 4'd4,
    PH_DATA     = 4'd5,
    PH_CRCHI    = 4'd6,
    PH_CRCLO    = 4'd7,
    PH_SUM      = 4'd8,
    PH_COMPLETE = 4'd9,
    PH_CANCEL   = 4'd10,
    PH_ESCAPE   = 4'd11,
    PH_SEQ_ERR  = 4'd12,
    PH_BAD_HDR  = 4'd13,
    PH_TIMEOUT  = 4'd14,
    PH_NO_RESP  = 4'd15
  } phase_e;

  // Configuration.
  logic use_crc_q;

  // Pipeline registers.
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;

  // Transfer state.
  phase_e                  phase_q, phase_d;
  logic [7:0]              expected_seq_q, expected_seq_d;
  logic [7:0]              header_seq_q, header_seq_d;
  logic [7:0]              header_seq_inv_q, header_seq_inv_d;
  logic [IDX_WIDTH-1:0]    data_index_q, data_index_d;
  logic                    long_packet_q, long_packet_d;
  logic [15:0]             crc_q, crc_d;
  logic [7:0]              sum_q, sum_d;
  logic [7:0]              check_high_q, check_high_d;
  logic [OFFSET_WIDTH-1:0] write_offset_q, write_offset_d;
  logic [23:0]             byte_total_q, byte_total_d;
  logic [5:0]              startup_tries_q, startup_tries_d;

  logic                    advance;
  logic                    do_step;
  logic [15:0]             crc_next;
  logic [IDX_WIDTH-1:0]    pkt_len;
  logic [IDX_WIDTH-1:0]    index_inc;
  logic [OFFSET_WIDTH-1:0] off_sum;
  logic [24:0]             total_sum;
  logic                    check_ok;
  logic                    seq_inv_ok;
  logic                    seq_match;
  logic                    seq_prev;
  logic                    start_tx_is_c;
  out_item_t               res;

  // The result register frees up when empty or when its item is taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign do_step    = in_valid_q && advance;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_USE_CRC) ? {31'd0, use_crc_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_crc_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_USE_CRC) begin
      use_crc_q <= pwdata[0];
    end
  end

  xmr_crc16_step u_crc (
    .crc_i  (crc_q),
    .byte_i (in_q.rx_byte),
    .crc_o  (crc_next)
  );

  assign pkt_len    = long_packet_q ? PKT_LEN_LONG : PKT_LEN_SHORT;
  assign index_inc  = data_index_q + IDX_WIDTH'(1);
  assign off_sum    = write_offset_q + OFFSET_WIDTH'(data_index_q);
  assign total_sum  = {1'b0, byte_total_q} + 25'(pkt_len);
  assign check_ok   = (phase_q == PH_CRCLO) ? ({check_high_q, in_q.rx_byte} == crc_q)
                                            : (in_q.rx_byte == sum_q);
  assign seq_inv_ok = (header_seq_q == ~header_seq_inv_q);
  assign seq_match  = (header_seq_q == expected_seq_q);
  assign seq_prev   = (header_seq_q == expected_seq_q - 8'd1);
  assign start_tx_is_c = use_crc_q;

  always_comb begin
    phase_d          = phase_q;
    expected_seq_d   = expected_seq_q;
    header_seq_d     = header_seq_q;
    header_seq_inv_d = header_seq_inv_q;
    data_index_d     = data_index_q;
    long_packet_d    = long_packet_q;
    crc_d            = crc_q;
    sum_d            = sum_q;
    check_high_d     = check_high_q;
    write_offset_d   = write_offset_q;
    byte_total_d     = byte_total_q;
    startup_tries_d  = startup_tries_q;
    res              = '0;

    if (do_step) begin
      unique case (in_q.command)
        CMD_START: begin
          expected_seq_d   = 8'd1;
          header_seq_d     = 8'd0;
          header_seq_inv_d = 8'd0;
          data_index_d     = '0;
          long_packet_d    = 1'b0;
          crc_d            = 16'd0;
          sum_d            = 8'd0;
          check_high_d     = 8'd0;
          write_offset_d   = '0;
          byte_total_d     = 24'd0;
          startup_tries_d  = 6'd1;
          phase_d          = PH_START;
          res.tx_valid     = 1'b1;
          res.tx_byte      = start_tx_is_c ? CH_CRC : CH_NAK;
        end
        CMD_EXPIRE: begin
          unique case (phase_q)
            PH_START: begin
              if (startup_tries_q >= 6'(MAX_STARTUP_TRIES)) begin
                phase_d = PH_NO_RESP;
              end else begin
                startup_tries_d = startup_tries_q + 6'd1;
                res.tx_valid    = 1'b1;
                res.tx_byte     = start_tx_is_c ? CH_CRC : CH_NAK;
              end
            end
            PH_HEADER: phase_d = PH_TIMEOUT;
            PH_SEQ, PH_SEQINV, PH_DATA: begin
              res.tx_valid = 1'b1;
              res.tx_byte  = CH_NAK;
              phase_d      = PH_HEADER;
            end
            // Inside the check bytes the sender gets no reply.
            PH_CRCHI, PH_CRCLO, PH_SUM: phase_d = PH_HEADER;
            default: ;
          endcase
        end
        CMD_BYTE: begin
          unique case (phase_q)
            PH_START, PH_HEADER: begin
              phase_d = PH_HEADER;
              unique case (in_q.rx_byte)
                CH_SOH, CH_STX: begin
                  long_packet_d = (in_q.rx_byte == CH_STX);
                  data_index_d  = '0;
                  crc_d         = 16'd0;
                  sum_d         = 8'd0;
                  phase_d       = PH_SEQ;
                end
                CH_EOT: begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = CH_ACK;
                  phase_d      = PH_COMPLETE;
                end
                CH_CAN: phase_d = PH_CANCEL;
                CH_ESC: phase_d = PH_ESCAPE;
                // A padding byte between packets is skipped.
                CH_SUB: ;
                default: phase_d = PH_BAD_HDR;
              endcase
            end
            PH_SEQ: begin
              header_seq_d = in_q.rx_byte;
              phase_d      = PH_SEQINV;
            end
            PH_SEQINV: begin
              header_seq_inv_d = in_q.rx_byte;
              phase_d          = PH_DATA;
            end
            PH_DATA: begin
              res.wr_valid  = 1'b1;
              res.wr_offset = 24'(off_sum);
              res.wr_byte   = in_q.rx_byte;
              crc_d         = crc_next;
              sum_d         = sum_q + in_q.rx_byte;
              data_index_d  = index_inc;
              if (index_inc >= pkt_len) begin
                phase_d = use_crc_q ? PH_CRCHI : PH_SUM;
              end
            end
            PH_CRCHI: begin
              check_high_d = in_q.rx_byte;
              phase_d      = PH_CRCLO;
            end
            PH_CRCLO, PH_SUM: begin
              phase_d      = PH_HEADER;
              res.tx_valid = 1'b1;
              // Checks go in order: check value, sequence complement, sequence.
              priority if (!check_ok || !seq_inv_ok) begin
                res.tx_byte = CH_NAK;
              end else if (seq_match) begin
                res.tx_byte    = CH_ACK;
                write_offset_d = write_offset_q + OFFSET_WIDTH'(pkt_len);
                expected_seq_d = expected_seq_q + 8'd1;
                byte_total_d   = total_sum[24] ? 24'hFF_FFFF : total_sum[23:0];
              end else if (seq_prev) begin
                res.tx_byte = CH_ACK;
              end else begin
                res.tx_byte = CH_CAN;
                phase_d     = PH_SEQ_ERR;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // Finished phases sit at 8 plus the status code, so the low bits give it.
    res.status      = phase_d[3] ? phase_d[2:0] : STATUS_BUSY;
    res.total_bytes = byte_total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      phase_q          <= PH_IDLE;
      expected_seq_q   <= 8'd1;
      header_seq_q     <= 8'd0;
      header_seq_inv_q <= 8'd0;
      data_index_q     <= '0;
      long_packet_q    <= 1'b0;
      crc_q            <= 16'd0;
      sum_q            <= 8'd0;
      check_high_q     <= 8'd0;
      write_offset_q   <= '0;
      byte_total_q     <= 24'd0;
      startup_tries_q  <= 6'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      phase_q          <= phase_d;
      expected_seq_q   <= expected_seq_d;
      header_seq_q     <= header_seq_d;
      header_seq_inv_q <= header_seq_inv_d;
      data_index_q     <= data_index_d;
      long_packet_q    <= long_packet_d;
      crc_q            <= crc_d;
      sum_q            <= sum_d;
      check_high_q     <= check_high_d;
      write_offset_q   <= write_offset_d;
      byte_total_q     <= byte_total_d;
      startup_tries_q  <= startup_tries_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (do_step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A held input item is not lost while the result side stalls.
  `XMR_ASSERT_NXT(a_hold_input, clk_i, rst_ni, in_valid_q && !advance, in_valid_q, "input item dropped during stall")
  // A payload write never coincides with a reply byte.
  `XMR_ASSERT_IMP(a_wr_no_tx, clk_i, rst_ni, out_valid_q && out_q.wr_valid, !out_q.tx_valid, "payload write and reply in one item")
  // A CAN reply is only sent when the transfer ends on a sequence error.
  `XMR_ASSERT_IMP(a_can_seq_err, clk_i, rst_ni, out_valid_q && out_q.tx_valid && out_q.tx_byte == CH_CAN, out_q.status == STATUS_SEQ_ERR, "CAN sent without sequence error")
  // The data index never runs past a long packet.
  `XMR_ASSERT_IMP(a_index_range, clk_i, rst_ni, 1'b1, data_index_q <= PKT_LEN_LONG, "data index out of range")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the XMODEM receiver: random and directed event streams,
// a transaction-level scoreboard and a check of every result item.
// Depends on xmr_pkg and xmodem_packet_receiver_unit.
`timescale 1ns / 1ps

module tb;
  import xmr_pkg::*;

  // Tracks the transfer state and predicts one result item per accepted item.
  class xmodem_rx_scoreboard;
    typedef enum logic [3:0] {
      RX_IDLE, RX_START, RX_HEADER, RX_SEQ, RX_SEQ_INV, RX_DATA,
      RX_CHECK_HI, RX_CHECK_LO, RX_SUM, RX_DONE
    } rx_phase_e;

    bit          crc_mode;
    rx_phase_e   phase;
    logic [2:0]  done_status;
    logic [7:0]  exp_seq;
    logic [7:0]  hdr_seq;
    logic [7:0]  hdr_seq_inv;
    logic [7:0]  check_hi;
    logic [7:0]  sum;
    logic [15:0] crc;
    logic [10:0] data_idx;
    bit          long_pkt;
    logic [23:0] base_offset;
    logic [23:0] byte_total;
    logic [5:0]  start_tries;
    out_item_t   owed_results[$];
    int          errors;
    int          results_seen;
    int          packets_taken;

    function new();
      crc_mode = 1'b0;
      phase = RX_IDLE;
      done_status = STATUS_BUSY;
      start_tries = '0;
      errors = 0;
      results_seen = 0;
      packets_taken = 0;
      clear_transfer();
    endfunction

    function void clear_transfer();
      exp_seq = 8'd1;
      hdr_seq = '0;
      hdr_seq_inv = '0;
      check_hi = '0;
      sum = '0;
      crc = '0;
      data_idx = '0;
      long_pkt = 1'b0;
      base_offset = '0;
      byte_total = '0;
    endfunction

    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
    endfunction

    function void open_packet(bit is_long);
      long_pkt = is_long;
      data_idx = '0;
      crc = '0;
      sum = '0;
      phase = RX_SEQ;
    endfunction

    function void close_transfer(logic [2:0] code);
      phase = RX_DONE;
      done_status = code;
    endfunction

    // Reply to a finished packet: check bytes first, then the complement,
    // then the sequence number.
    function logic [7:0] judge_packet(bit check_ok);
      logic [10:0] len;
      logic [24:0] grown;
      if (!check_ok || hdr_seq != 8'(~hdr_seq_inv)) return CH_NAK;
      if (hdr_seq != exp_seq) begin
        if (hdr_seq == 8'(exp_seq - 8'd1)) return CH_ACK;
        close_transfer(STATUS_SEQ_ERR);
        return CH_CAN;
      end
      len = long_pkt ? PKT_LEN_LONG : PKT_LEN_SHORT;
      base_offset = base_offset + 24'(len);
      exp_seq = exp_seq + 8'd1;
      grown = {1'b0, byte_total} + 25'(len);
      byte_total = grown[24] ? 24'hFF_FFFF : grown[23:0];
      packets_taken++;
      return CH_ACK;
    endfunction

    function out_item_t step_transfer(in_item_t it);
      out_item_t r;
      logic [10:0] len;
      r = '0;
      len = long_pkt ? PKT_LEN_LONG : PKT_LEN_SHORT;
      case (it.command)
        CMD_START: begin
          clear_transfer();
          start_tries = 6'd1;
          phase = RX_START;
          r.tx_valid = 1'b1;
          r.tx_byte = crc_mode ? CH_CRC : CH_NAK;
        end
        CMD_EXPIRE: begin
          case (phase)
            RX_START: begin
              if (start_tries >= 6'(MAX_STARTUP_TRIES_DEFAULT)) begin
                close_transfer(STATUS_NO_RESP);
              end else begin
                start_tries = start_tries + 6'd1;
                r.tx_valid = 1'b1;
                r.tx_byte = crc_mode ? CH_CRC : CH_NAK;
              end
            end
            RX_HEADER: close_transfer(STATUS_TIMEOUT);
            RX_SEQ, RX_SEQ_INV, RX_DATA: begin
              r.tx_valid = 1'b1;
              r.tx_byte = CH_NAK;
              phase = RX_HEADER;
            end
            // A stall inside the check bytes goes back quietly.
            RX_CHECK_HI, RX_CHECK_LO, RX_SUM: phase = RX_HEADER;
            default: ;
          endcase
        end
        CMD_BYTE: begin
          case (phase)
            RX_START, RX_HEADER: begin
              phase = RX_HEADER;
              case (it.rx_byte)
                CH_SOH: open_packet(1'b0);
                CH_STX: open_packet(1'b1);
                CH_EOT: begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = CH_ACK;
                  close_transfer(STATUS_COMPLETE);
                end
                CH_CAN: close_transfer(STATUS_CANCELLED);
                CH_ESC: close_transfer(STATUS_ESCAPE);
                CH_SUB: ;
                default: close_transfer(STATUS_BAD_HDR);
              endcase
            end
            RX_SEQ: begin
              hdr_seq = it.rx_byte;
              phase = RX_SEQ_INV;
            end
            RX_SEQ_INV: begin
              hdr_seq_inv = it.rx_byte;
              phase = RX_DATA;
            end
            RX_DATA: begin
              r.wr_valid = 1'b1;
              r.wr_offset = base_offset + 24'(data_idx);
              r.wr_byte = it.rx_byte;
              crc = crc_next(crc, it.rx_byte);
              sum = sum + it.rx_byte;
              data_idx = data_idx + 11'd1;
              // The check length is fixed by the mode at the last data byte.
              if (data_idx >= len) phase = crc_mode ? RX_CHECK_HI : RX_SUM;
            end
            RX_CHECK_HI: begin
              check_hi = it.rx_byte;
              phase = RX_CHECK_LO;
            end
            RX_CHECK_LO: begin
              phase = RX_HEADER;
              r.tx_valid = 1'b1;
              r.tx_byte = judge_packet({check_hi, it.rx_byte} == crc);
            end
            RX_SUM: begin
              phase = RX_HEADER;
              r.tx_valid = 1'b1;
              r.tx_byte = judge_packet(it.rx_byte == sum);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.status = (phase == RX_DONE) ? done_status : STATUS_BUSY;
      r.total_bytes = byte_total;
      return r;
    endfunction

    function void note_item(in_item_t it);
      owed_results.push_back(step_transfer(it));
    endfunction

    function int field_differs(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = owed_results.pop_front();
      errors += field_differs("tx_valid", want.tx_valid, got.tx_valid);
      errors += field_differs("tx_byte", want.tx_byte, got.tx_byte);
      errors += field_differs("wr_valid", want.wr_valid, got.wr_valid);
      errors += field_differs("wr_offset", want.wr_offset, got.wr_offset);
      errors += field_differs("wr_byte", want.wr_byte, got.wr_byte);
      errors += field_differs("status", want.status, got.status);
      errors += field_differs("total_bytes", want.total_bytes, got.total_bytes);
    endfunction
  endclass

  typedef enum int {
    PKT_GOOD, PKT_DUPLICATE, PKT_WRONG_SEQ, PKT_BAD_CHECK, PKT_BAD_COMPLEMENT,
    PKT_STALL_SEQ, PKT_STALL_DATA, PKT_STALL_CHECK, PKT_MODE_FLIP
  } pkt_flaw_e;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] ADDR_USE_CRC = {CFG_IDX_USE_CRC, 2'b00};
  localparam int RANDOM_ITEMS = 1800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  xmodem_rx_scoreboard sb;
  int        stall_pct = 30;
  int        items_sent = 0;
  bit        cfg_crc = 1'b0;
  logic [7:0] next_seq = 8'd1;

  xmodem_packet_receiver_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_item(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  task automatic push(logic [1:0] cmd, logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < stall_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= in_item_t'{command: cmd, rx_byte: b};
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  // Let every owed result drain, plus the pipeline depth.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write use_crc, then read it back in a back-to-back transfer.
  task automatic set_crc_mode(bit val);
    settle();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_USE_CRC;
    pwdata <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.crc_mode = val;
    cfg_crc = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(val)) begin
      sb.errors++;
      $display("%0t: use_crc read expected %0h, got %0h", $time, 32'(val), prdata);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_packet(bit is_long, pkt_flaw_e flaw);
    logic [7:0]  seq;
    logic [7:0]  inv;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [15:0] crc;
    int          len;
    int          ndata;
    int          fill;
    bit          mode;
    len = is_long ? 1024 : 128;
    seq = next_seq;
    if (flaw == PKT_DUPLICATE) seq = next_seq - 8'd1;
    // Anything but the expected number or the one before it.
    if (flaw == PKT_WRONG_SEQ) seq = next_seq + 8'($urandom_range(1, 254));
    inv = ~seq;
    if (flaw == PKT_BAD_COMPLEMENT) inv = inv ^ 8'($urandom_range(1, 255));
    push(CMD_BYTE, is_long ? CH_STX : CH_SOH);
    if (flaw == PKT_STALL_SEQ) begin
      if ($urandom_range(1) != 0) push(CMD_BYTE, seq);
      push(CMD_EXPIRE, 8'($urandom));
      return;
    end
    push(CMD_BYTE, seq);
    push(CMD_BYTE, inv);
    ndata = (flaw == PKT_STALL_DATA) ? $urandom_range(len - 1) : len;
    fill = $urandom_range(9);
    crc = '0;
    sum = '0;
    for (int i = 0; i < ndata; i++) begin
      case (fill)
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      crc = xmodem_rx_scoreboard::crc_next(crc, b);
      sum = sum + b;
      push(CMD_BYTE, b);
    end
    if (flaw == PKT_STALL_DATA) begin
      push(CMD_EXPIRE, 8'($urandom));
      return;
    end
    mode = cfg_crc;
    // A mode change now must only take effect from the next packet on.
    if (flaw == PKT_MODE_FLIP) set_crc_mode(!cfg_crc);
    if (flaw == PKT_STALL_CHECK) begin
      if (mode && $urandom_range(1) != 0) push(CMD_BYTE, crc[15:8]);
      push(CMD_EXPIRE, 8'($urandom));
      return;
    end
    if (flaw == PKT_BAD_CHECK) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    if (mode) begin
      push(CMD_BYTE, crc[15:8]);
      push(CMD_BYTE, crc[7:0]);
    end else begin
      push(CMD_BYTE, sum);
    end
    if (flaw == PKT_GOOD || flaw == PKT_MODE_FLIP) next_seq = next_seq + 8'd1;
  endtask

  task automatic run_transfer(bit force_long);
    pkt_flaw_e flaw;
    int        npk;
    int        r;
    if ($urandom_range(3) == 0) set_crc_mode($urandom_range(1));
    push(CMD_START, 8'($urandom));
    next_seq = 8'd1;
    repeat ($urandom_range(2)) push(CMD_EXPIRE, 8'($urandom));
    if ($urandom_range(3) == 0) push(CMD_BYTE, CH_SUB);
    npk = $urandom_range(1, 3);
    for (int k = 0; k < npk; k++) begin
      if ($urandom_range(4) == 0) push(CMD_BYTE, CH_SUB);
      r = $urandom_range(99);
      if (force_long && k == 0) flaw = PKT_GOOD;
      else if (r < 45) flaw = PKT_GOOD;
      else if (r < 55) flaw = PKT_DUPLICATE;
      else if (r < 62) flaw = PKT_WRONG_SEQ;
      else if (r < 70) flaw = PKT_BAD_CHECK;
      else if (r < 76) flaw = PKT_BAD_COMPLEMENT;
      else if (r < 82) flaw = PKT_STALL_SEQ;
      else if (r < 88) flaw = PKT_STALL_DATA;
      else if (r < 94) flaw = PKT_STALL_CHECK;
      else flaw = PKT_MODE_FLIP;
      send_packet(force_long && k == 0, flaw);
      if (flaw == PKT_WRONG_SEQ) return;
    end
    r = $urandom_range(9);
    if (r < 6) push(CMD_BYTE, CH_EOT);
    else if (r == 6) push(CMD_BYTE, CH_CAN);
    else if (r == 7) push(CMD_BYTE, CH_ESC);
    else if (r == 8) push(CMD_EXPIRE, 8'($urandom));
    else push(CMD_BYTE, 8'($urandom));
    // Events after the end of a transfer must leave it alone.
    repeat ($urandom_range(2)) push(2'($urandom_range(1, 3)), 8'($urandom));
  endtask

  // The sender never answers: retries run out and the transfer gives up.
  task automatic exhaust_startup();
    push(CMD_START, 8'($urandom));
    next_seq = 8'd1;
    for (int i = 0; i < MAX_STARTUP_TRIES_DEFAULT + 1; i++) begin
      if (i == 16 && $urandom_range(1) != 0) set_crc_mode(!cfg_crc);
      push(CMD_EXPIRE, 8'($urandom));
    end
  endtask

  initial begin
    int directed_items;
    int pick;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_crc_mode(1'b0);
    push(CMD_START, 8'h00);
    push(CMD_EXPIRE, 8'hFF);
    push(CMD_BYTE, CH_SUB);
    push(CMD_EXPIRE, 8'h00);
    push(CMD_BYTE, 8'h55);
    push(CMD_UNUSED, 8'hFF);
    push(CMD_EXPIRE, 8'h00);
    push(CMD_START, 8'h00);
    push(CMD_BYTE, CH_EOT);
    push(CMD_START, 8'h00);
    push(CMD_BYTE, CH_CAN);
    push(CMD_START, 8'h00);
    push(CMD_BYTE, CH_ESC);
    push(CMD_START, 8'h00);
    push(CMD_BYTE, 8'h00);
    set_crc_mode(1'b1);
    push(CMD_START, 8'hFF);
    push(CMD_BYTE, CH_SOH);
    push(CMD_BYTE, 8'h01);
    push(CMD_BYTE, 8'hFE);
    push(CMD_EXPIRE, 8'h00);
    push(CMD_BYTE, CH_STX);
    push(CMD_BYTE, 8'hFF);
    push(CMD_EXPIRE, 8'h00);
    push(CMD_EXPIRE, 8'h00);
    directed_items = items_sent;

    // One long packet with no idling on either side.
    stall_pct = 0;
    run_transfer(1'b1);
    stall_pct = 30;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        run_transfer(1'b0);
      end else if (pick == 7) begin
        exhaust_startup();
      end else begin
        repeat ($urandom_range(5, 20)) push(2'($urandom_range(3)), 8'($urandom));
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Summary: %0d items sent, %0d results checked, %0d packets accepted.",
             items_sent, sb.results_seen, sb.packets_taken);
    $display("Summary: both check modes, all header bytes, stalls and startup give-up.");
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
